>>> src/assert_macros.svh
// Assertion helpers included by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define RBST_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ray box slab test check failed");

// Checks that a condition at one edge implies a consequence at the next edge.
`define RBST_ASSERT_NEXT(name, cond, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error("ray box slab test sequence check failed");

`endif

>>> src/rbst_pkg.sv
`default_nettype none
package rbst_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_IDX_W     = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Z = 3'd5;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic        [30:0] max_dist;
  } ray_in_t;

  typedef struct packed {
    logic        hit;
    logic [30:0] t_enter;
    logic [30:0] t_exit;
  } ray_out_t;

  // What one axis lane reports to the merging stage.
  typedef struct packed {
    logic signed [31:0] t_near;
    logic signed [31:0] t_far;
    logic               dir_zero;
    logic               in_slab;
  } lane_res_t;

endpackage
`default_nettype wire

>>> src/rbst_div.sv
`default_nettype none
module rbst_div
  import rbst_pkg::*;
#(
  parameter int NUM_W = 49,
  parameter int DEN_W = 32
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  input  wire logic             neg_i,
  output      logic [NUM_W-1:0] quo_o,
  output      logic             neg_o
);

  // One quotient bit per stage; the accumulator shifts numerator bits out
  // at the top and quotient bits in at the bottom.
  logic [DEN_W-1:0] rem_q [NUM_W];
  logic [NUM_W-1:0] acc_q [NUM_W];
  logic [DEN_W-1:0] den_q [NUM_W];
  logic             neg_q [NUM_W];

  genvar s;
  for (s = 0; s < NUM_W; s++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [NUM_W-1:0] acc_in;
    logic [DEN_W-1:0] den_in;
    logic             neg_in;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign acc_in = num_i;
      assign den_in = den_i;
      assign neg_in = neg_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign acc_in = acc_q[s-1];
      assign den_in = den_q[s-1];
      assign neg_in = neg_q[s-1];
    end

    // Trial subtraction of the divisor from the shifted remainder.
    assign trial = {rem_in, acc_in[NUM_W-1]};
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= diff[DEN_W] ? trial[DEN_W-1:0] : diff[DEN_W-1:0];
        acc_q[s] <= {acc_in[NUM_W-2:0], ~diff[DEN_W]};
        den_q[s] <= den_in;
        neg_q[s] <= neg_in;
      end
    end
  end

  assign quo_o = acc_q[NUM_W-1];
  assign neg_o = neg_q[NUM_W-1];

endmodule
`default_nettype wire

>>> src/rbst_lane.sv
`default_nettype none
module rbst_lane
  import rbst_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [31:0] org_i,
  input  wire logic signed [31:0] dir_i,
  input  wire logic signed [31:0] bmin_i,
  input  wire logic signed [31:0] bmax_i,
  output      lane_res_t          res_o
);

  localparam int NUM_W = 33 + FRAC_BITS;

  logic signed [32:0] dlo, dhi;
  logic        [32:0] mag_lo, mag_hi;
  logic        [31:0] dmag;

  logic [NUM_W-1:0] num_lo_q, num_hi_q;
  logic [31:0]      dmag_q;
  logic             neg_lo_q, neg_hi_q;
  logic             zero_q [NUM_W+1];
  logic             pass_q [NUM_W+1];

  // Exact corner distances and their magnitudes.
  assign dlo    = {bmin_i[31], bmin_i} - {org_i[31], org_i};
  assign dhi    = {bmax_i[31], bmax_i} - {org_i[31], org_i};
  assign mag_lo = dlo[32] ? (~dlo + 33'd1) : dlo;
  assign mag_hi = dhi[32] ? (~dhi + 33'd1) : dhi;
  assign dmag   = dir_i[31] ? (~dir_i + 32'd1) : dir_i;

  // Input stage, followed by a delay line for the zero-direction and in-slab flags.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_lo_q  <= NUM_W'(mag_lo) << FRAC_BITS;
      num_hi_q  <= NUM_W'(mag_hi) << FRAC_BITS;
      neg_lo_q  <= dlo[32] ^ dir_i[31];
      neg_hi_q  <= dhi[32] ^ dir_i[31];
      dmag_q    <= dmag;
      zero_q[0] <= (dir_i == 32'sd0);
      pass_q[0] <= (org_i >= bmin_i) && (org_i <= bmax_i);
      for (int k = 1; k <= NUM_W; k++) begin
        zero_q[k] <= zero_q[k-1];
        pass_q[k] <= pass_q[k-1];
      end
    end
  end

  logic [NUM_W-1:0] q_lo, q_hi;
  logic             qn_lo, qn_hi;

  rbst_div #(.NUM_W(NUM_W), .DEN_W(32)) u_div_lo (
    .clk_i (clk_i), .en_i (en_i), .num_i (num_lo_q), .den_i (dmag_q),
    .neg_i (neg_lo_q), .quo_o (q_lo), .neg_o (qn_lo)
  );

  rbst_div #(.NUM_W(NUM_W), .DEN_W(32)) u_div_hi (
    .clk_i (clk_i), .en_i (en_i), .num_i (num_hi_q), .den_i (dmag_q),
    .neg_i (neg_hi_q), .quo_o (q_hi), .neg_o (qn_hi)
  );

  // Apply the sign and saturate to the signed 32-bit range.
  function automatic logic signed [31:0] sat_q(input logic [NUM_W-1:0] q, input logic neg);
    logic ovf_pos, ovf_neg;
    ovf_pos = |q[NUM_W-1:31];
    ovf_neg = (|q[NUM_W-1:32]) || (q[31] && (|q[30:0]));
    if (!neg) begin
      sat_q = ovf_pos ? 32'sh7FFF_FFFF : $signed(q[31:0]);
    end else begin
      sat_q = ovf_neg ? 32'sh8000_0000 : $signed(~q[31:0] + 32'd1);
    end
  endfunction

  logic signed [31:0] t_lo, t_hi;
  lane_res_t          res_q;

  assign t_lo = sat_q(q_lo, qn_lo);
  assign t_hi = sat_q(q_hi, qn_hi);

  // Order the two distances and register the lane result.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q.t_near   <= (t_lo > t_hi) ? t_hi : t_lo;
      res_q.t_far    <= (t_lo > t_hi) ? t_lo : t_hi;
      res_q.dir_zero <= zero_q[NUM_W];
      res_q.in_slab  <= pass_q[NUM_W];
    end
  end

  assign res_o = res_q;

endmodule
`default_nettype wire

>>> src/rbst_merge.sv
`default_nettype none
module rbst_merge
  import rbst_pkg::*;
(
  input  wire lane_res_t   lane_i [3],
  input  wire logic [30:0] max_dist_i,
  output      ray_out_t    res_o
);

  logic signed [31:0] t0, t1;
  logic               ok;

  // Narrow the interval over the lanes with a nonzero direction; a lane
  // with a zero direction only has to hold the origin inside its slab.
  always_comb begin
    t0 = 32'sd0;
    t1 = $signed({1'b0, max_dist_i});
    ok = 1'b1;
    for (int a = 0; a < 3; a++) begin
      if (lane_i[a].dir_zero) begin
        ok = ok && lane_i[a].in_slab;
      end else begin
        if (lane_i[a].t_near > t0) t0 = lane_i[a].t_near;
        if (lane_i[a].t_far < t1)  t1 = lane_i[a].t_far;
      end
    end
    res_o.hit     = ok && (t0 <= t1);
    res_o.t_enter = res_o.hit ? t0[30:0] : 31'd0;
    res_o.t_exit  = res_o.hit ? t1[30:0] : 31'd0;
  end

endmodule
`default_nettype wire

>>> src/ray_box_slab_test_unit.sv
// Throughput: one ray per cycle; each axis lane has two divider pipelines retiring
// one quotient bit per stage, so every stage accepts a new ray each cycle; the whole
// pipeline holds while the output register is full and not taken.
// Reset clears the box registers to zero and all valid flags; no clearing pass.
`default_nettype none
`include "assert_macros.svh"
module ray_box_slab_test_unit
  import rbst_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output      logic                 in_ready_o,
  input  wire ray_in_t              in_data_i,
  output      logic                 out_valid_o,
  input  wire logic                 out_ready_i,
  output      ray_out_t             out_data_o,
  input  wire logic                 cfg_valid_i,
  output      logic                 cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [31:0]          cfg_data_i
);

  // Input stage, divider stages and lane output register.
  localparam int PIPE_LEN = 33 + FRAC_BITS + 2;

  logic signed [31:0] bmin_q [3];
  logic signed [31:0] bmax_q [3];

  // Box corner registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        bmin_q[a] <= 32'sd0;
        bmax_q[a] <= 32'sd0;
      end
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_BOX_MIN_X: bmin_q[0] <= cfg_data_i;
        REG_BOX_MIN_Y: bmin_q[1] <= cfg_data_i;
        REG_BOX_MIN_Z: bmin_q[2] <= cfg_data_i;
        REG_BOX_MAX_X: bmax_q[0] <= cfg_data_i;
        REG_BOX_MAX_Y: bmax_q[1] <= cfg_data_i;
        REG_BOX_MAX_Z: bmax_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // The pipeline advances whenever the output register can take a result.
  logic     en;
  logic     out_valid_q;
  ray_out_t out_data_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  logic        vld_q [PIPE_LEN];
  logic [30:0] md_q  [PIPE_LEN];

  // Valid flags and max distance travel alongside the lanes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < PIPE_LEN; k++) vld_q[k] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int k = 1; k < PIPE_LEN; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      md_q[0] <= in_data_i.max_dist;
      for (int k = 1; k < PIPE_LEN; k++) md_q[k] <= md_q[k-1];
    end
  end

  lane_res_t lane_res [3];

  rbst_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
    .clk_i (clk_i), .en_i (en), .org_i (in_data_i.origin_x), .dir_i (in_data_i.dir_x),
    .bmin_i (bmin_q[0]), .bmax_i (bmax_q[0]), .res_o (lane_res[0])
  );

  rbst_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
    .clk_i (clk_i), .en_i (en), .org_i (in_data_i.origin_y), .dir_i (in_data_i.dir_y),
    .bmin_i (bmin_q[1]), .bmax_i (bmax_q[1]), .res_o (lane_res[1])
  );

  rbst_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_z (
    .clk_i (clk_i), .en_i (en), .org_i (in_data_i.origin_z), .dir_i (in_data_i.dir_z),
    .bmin_i (bmin_q[2]), .bmax_i (bmax_q[2]), .res_o (lane_res[2])
  );

  ray_out_t merged;

  rbst_merge u_merge (
    .lane_i     (lane_res),
    .max_dist_i (md_q[PIPE_LEN-1]),
    .res_o      (merged)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld_q[PIPE_LEN-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= merged;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A miss reports an empty interval.
  `RBST_ASSERT(a_miss_zero, (out_valid_o && !out_data_o.hit) |->
    (out_data_o.t_enter == 31'd0 && out_data_o.t_exit == 31'd0))
  // A hit reports an ordered interval.
  `RBST_ASSERT(a_hit_order, (out_valid_o && out_data_o.hit) |->
    (out_data_o.t_enter <= out_data_o.t_exit))
  // A result waiting for the consumer is not dropped.
  `RBST_ASSERT_NEXT(a_out_kept, out_valid_o && !out_ready_i, out_valid_o)

endmodule
`default_nettype wire

>>> tb/tb_top.sv
`default_nettype none
module tb_top;
  import rbst_pkg::*;

  localparam int LATENCY = FRAC_BITS_DEF + 36;
  localparam int N_RANDOM = 1300;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  ray_in_t              in_data_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  ray_out_t             out_data_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [31:0]          cfg_data_i;

  ray_box_slab_test_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  // Box corners as the predictor sees them.
  logic signed [31:0] box_lo [3];
  logic signed [31:0] box_hi [3];

  ray_out_t hits_pending[$];
  int       errors;
  int       send_idle_pct;
  int       recv_stall_pct;
  bit       hold_off;

  // Directed rows; check_row set means the typed expectation is compared too.
  typedef struct {
    ray_in_t  ray;
    bit       check_row;
    ray_out_t want;
  } ray_row_t;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Safety net against a hung handshake.
  initial begin
    #(12 * 1500000);
    $display("TEST FAILED");
    $finish;
  end

  // Saturated slab distance, truncated toward zero.
  function automatic logic signed [63:0] slab_t(input logic signed [31:0] corner,
                                                input logic signed [31:0] org,
                                                input logic signed [31:0] dir);
    logic signed [63:0] diff;
    logic signed [63:0] q;
    diff = 64'(corner) - 64'(org);
    q = (diff <<< FRAC_BITS_DEF) / 64'(dir);
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q;
  endfunction

  // Runs the three-axis slab test on one ray.
  function automatic ray_out_t clip_ray(input ray_in_t r);
    logic signed [31:0] org [3];
    logic signed [31:0] dir [3];
    logic signed [63:0] t0, t1, tn, tf, tmp;
    bit hit;
    ray_out_t res;
    org = '{r.origin_x, r.origin_y, r.origin_z};
    dir = '{r.dir_x, r.dir_y, r.dir_z};
    t0 = 0;
    t1 = 64'(r.max_dist);
    hit = 1'b1;
    for (int a = 0; a < 3 && hit; a++) begin
      if (dir[a] == 0) begin
        if (org[a] < box_lo[a] || org[a] > box_hi[a]) hit = 1'b0;
      end else begin
        tn = slab_t(box_lo[a], org[a], dir[a]);
        tf = slab_t(box_hi[a], org[a], dir[a]);
        if (tn > tf) begin
          tmp = tn; tn = tf; tf = tmp;
        end
        if (tn > t0) t0 = tn;
        if (tf < t1) t1 = tf;
        if (t0 > t1) hit = 1'b0;
      end
    end
    res.hit = hit;
    res.t_enter = hit ? t0[30:0] : '0;
    res.t_exit = hit ? t1[30:0] : '0;
    return res;
  endfunction

  // Offers one register write and waits for it to be taken; valid stays high.
  task automatic write_box(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx < REG_BOX_MAX_X) box_lo[idx] = val;
    else box_hi[idx - REG_BOX_MAX_X] = val;
  endtask

  task automatic set_box(input logic [31:0] lx, ly, lz, hx, hy, hz);
    write_box(REG_BOX_MIN_X, lx);
    write_box(REG_BOX_MIN_Y, ly);
    write_box(REG_BOX_MIN_Z, lz);
    write_box(REG_BOX_MAX_X, hx);
    write_box(REG_BOX_MAX_Y, hy);
    write_box(REG_BOX_MAX_Z, hz);
    cfg_valid_i <= 1'b0;
  endtask

  // Wait until every result is in, then let the pipeline run dry.
  task automatic drain;
    while (hits_pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic send_ray(input ray_in_t r);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    hits_pending.push_back(clip_ray(r));
  endtask

  task automatic stop_sending;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord;
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(8) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
      2: return 32'(int'($urandom_range(40 << 16)) - (20 << 16));
      default: return 32'(int'($urandom_range(8 << 16)) - (4 << 16));
    endcase
  endfunction

  function automatic logic [31:0] rand_dir;
    case ($urandom_range(7))
      0: return '0;
      1: return $urandom;
      2: return $urandom_range(1) ? 32'h0000_0001 : 32'hffff_ffff;
      default: return 32'(int'($urandom_range(4 << 16)) - (2 << 16));
    endcase
  endfunction

  function automatic ray_in_t rand_ray;
    ray_in_t r;
    r.origin_x = rand_coord(); r.origin_y = rand_coord(); r.origin_z = rand_coord();
    r.dir_x = rand_dir(); r.dir_y = rand_dir(); r.dir_z = rand_dir();
    case ($urandom_range(3))
      0: r.max_dist = 31'($urandom);
      1: r.max_dist = $urandom_range(1) ? '0 : 31'h7fff_ffff;
      default: r.max_dist = 31'($urandom_range(64 << 16));
    endcase
    return r;
  endfunction

  function automatic ray_in_t mk_ray(input logic [31:0] ox, oy, oz, dx, dy, dz,
                                     input logic [30:0] md);
    ray_in_t r;
    r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
    r.dir_x = dx; r.dir_y = dy; r.dir_z = dz; r.max_dist = md;
    return r;
  endfunction

  // Receiver: random stalls plus one long hold-off on request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= !hold_off &&
                     !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  // Result checker against the oldest expectation.
  always @(posedge clk_i) begin
    ray_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (hits_pending.size() == 0) begin
        $display("%0t: unexpected result hit=%0b enter=%h exit=%h", $time,
                 out_data_o.hit, out_data_o.t_enter, out_data_o.t_exit);
        errors++;
      end else begin
        want = hits_pending.pop_front();
        if (out_data_o.hit !== want.hit)
          begin
            $display("%0t: hit expected %0b actual %0b", $time, want.hit, out_data_o.hit);
            errors++;
          end
        if (out_data_o.t_enter !== want.t_enter) begin
          $display("%0t: t_enter expected %h actual %h", $time, want.t_enter,
                   out_data_o.t_enter);
          errors++;
        end
        if (out_data_o.t_exit !== want.t_exit) begin
          $display("%0t: t_exit expected %h actual %h", $time, want.t_exit,
                   out_data_o.t_exit);
          errors++;
        end
      end
    end
  end

  initial begin
    ray_row_t rows[$];
    ray_row_t row;
    ray_out_t miss;
    int phase_len;
    miss = '0;
    errors = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_BOX_MIN_X;
    cfg_data_i = '0;
    for (int a = 0; a < 3; a++) begin
      box_lo[a] = '0;
      box_hi[a] = '0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // After reset the box is the single point at the origin.
    row = '{mk_ray(0, 0, 0, 0, 0, 0, 31'h100), 1'b1, '{1'b1, 31'd0, 31'h100}};
    rows.push_back(row);
    row = '{mk_ray(1, 0, 0, 0, 0, 0, 31'h100), 1'b1, miss};
    rows.push_back(row);
    foreach (rows[i]) send_ray(rows[i].ray);
    stop_sending();
    drain();
    foreach (rows[i])
      if (rows[i].check_row && clip_ray(rows[i].ray) != rows[i].want) begin
        $display("%0t: typed row %0d disagrees with predictor", $time, i);
        errors++;
      end
    rows.delete();

    // Unit box from -1 to 1 on each axis.
    set_box(32'hffff_0000, 32'hffff_0000, 32'hffff_0000,
            32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    // Zero direction inside the slab, on the bound and outside it.
    row = '{mk_ray(0, 0, 0, 0, 0, 0, 31'h7fff_ffff), 1'b1, '{1'b1, 31'd0, 31'h7fff_ffff}};
    rows.push_back(row);
    row = '{mk_ray(32'h0001_0000, 32'hffff_0000, 0, 0, 0, 0, 31'd5), 1'b1,
            '{1'b1, 31'd0, 31'd5}};
    rows.push_back(row);
    row = '{mk_ray(32'h0001_0001, 0, 0, 0, 0, 0, 31'd5), 1'b1, miss};
    rows.push_back(row);
    // Ray along x from -4, hits between 3 and 5.
    row = '{mk_ray(32'hfffc_0000, 0, 0, 32'h0001_0000, 0, 0, 31'h7fff_ffff), 1'b1,
            '{1'b1, 31'h0003_0000, 31'h0005_0000}};
    rows.push_back(row);
    // Same ray cut short; early miss.
    row = '{mk_ray(32'hfffc_0000, 0, 0, 32'h0001_0000, 0, 0, 31'h0002_0000), 1'b1, miss};
    rows.push_back(row);
    // Zero max_dist from inside and from outside.
    row = '{mk_ray(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 31'd0), 1'b1,
            '{1'b1, 31'd0, 31'd0}};
    rows.push_back(row);
    row = '{mk_ray(32'h0002_0000, 0, 0, 32'h0001_0000, 0, 0, 31'd0), 1'b1, miss};
    rows.push_back(row);
    // Extremes: tiny directions saturate, huge ones round to zero.
    row = '{mk_ray(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001,
                   32'hffff_ffff, 32'h7fff_ffff, 31'h7fff_ffff), 1'b0, miss};
    rows.push_back(row);
    row = '{mk_ray(0, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   31'h7fff_ffff), 1'b0, miss};
    rows.push_back(row);
    row = '{mk_ray(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff,
                   32'hffff_ffff, 32'hffff_ffff, 31'h7fff_ffff), 1'b0, miss};
    rows.push_back(row);
    row = '{mk_ray(32'h0000_8000, 32'hffff_8000, 0, 32'hffff_0000, 32'h0001_0000,
                   32'h0000_0003, 31'h0040_0000), 1'b0, miss};
    rows.push_back(row);
    foreach (rows[i]) send_ray(rows[i].ray);
    stop_sending();
    drain();
    foreach (rows[i])
      if (rows[i].check_row && clip_ray(rows[i].ray) != rows[i].want) begin
        $display("%0t: typed row %0d disagrees with predictor", $time, i);
        errors++;
      end
    rows.delete();

    // Inverted box: zero direction must miss, nonzero still works.
    set_box(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
            32'hffff_0000, 32'hffff_0000, 32'hffff_0000);
    send_ray(mk_ray(0, 0, 0, 0, 0, 0, 31'd100));
    send_ray(mk_ray(0, 0, 0, 32'h0001_0000, 32'h0002_0000, 32'hffff_0000,
                    31'h7fff_ffff));
    stop_sending();
    drain();

    // Random phases, each with its own box and idling mix.
    phase_len = N_RANDOM / 6;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_box(32'hfffe_0000, 32'hfffd_0000, 32'hffff_0000,
                   32'h0002_0000, 32'h0003_0000, 32'h0001_0000);
        1: set_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        5: set_box(32'h7fff_ffff, 32'h8000_0000, $urandom, 32'h8000_0000,
                   32'h7fff_ffff, $urandom);
        default: set_box(rand_coord(), rand_coord(), rand_coord(),
                         rand_coord(), rand_coord(), rand_coord());
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      // In one phase the receiver stops long enough for the input to back up.
      if (ph == 4) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (3 * LATENCY) @(posedge clk_i);
            hold_off = 1'b0;
          end
        join_none
      end
      for (int n = 0; n < phase_len; n++) begin
        send_ray(rand_ray());
        // In one phase the sender pauses halfway until everything outstanding is back.
        if (ph == 3 && n == phase_len / 2) begin
          stop_sending();
          while (hits_pending.size() != 0) @(posedge clk_i);
        end
      end
      stop_sending();
      drain();
    end

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
